// ----- rtl/record_region_interval_splitter_core_defines.svh -----
// Assertion macros for the region interval splitter
`ifndef RECORD_REGION_INTERVAL_SPLITTER_CORE_DEFINES_SVH
`define RECORD_REGION_INTERVAL_SPLITTER_CORE_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define RRIS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rris check failed");
// next-cycle implication checked outside reset
`define RRIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rris check failed");
`endif

// ----- rtl/rris_pkg.sv -----
// ----------------------------------------------------------------------------
// rris_pkg
// Shared types and constants of the region interval splitter.
// ----------------------------------------------------------------------------
package rris_pkg;
  localparam int unsigned PosWidth    = 32;
  localparam int unsigned RegionDepth = 1024;
  localparam int unsigned ChromCount  = 64;
  localparam int unsigned MaxSegments = 64;
  localparam int unsigned SlotWidth   = $clog2(RegionDepth);
  localparam int unsigned PtrWidth    = SlotWidth + 1;
  localparam int unsigned ChromWidth  = $clog2(ChromCount);
  localparam int unsigned SegCntWidth = $clog2(MaxSegments);

  typedef logic [PosWidth-1:0] pos_t;
  typedef logic [PtrWidth-1:0] ptr_t;

  localparam logic [1:0] ReqRegion = 2'd0;
  localparam logic [1:0] ReqDir    = 2'd1;
  localparam logic [1:0] ReqRecord = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIR,
    ST_WALK_RD,
    ST_WALK,
    ST_SEG_RD,
    ST_SEG,
    ST_OUT
  } state_t;

  // one result item
  typedef struct packed {
    pos_t seg_begin;
    pos_t seg_end;
    logic in_region;
    logic passed_through;
    logic overflowed;
    logic last_segment;
  } result_t;
endpackage

// ----- rtl/rris_region_mem.sv -----
// ----------------------------------------------------------------------------
// rris_region_mem
// Region table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rris_region_mem (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [rris_pkg::SlotWidth-1:0] wr_addr,
  input  rris_pkg::pos_t                 wr_start,
  input  rris_pkg::pos_t                 wr_stop,
  input  logic [rris_pkg::SlotWidth-1:0] rd_addr,
  output rris_pkg::pos_t                 rd_start,
  output rris_pkg::pos_t                 rd_stop
);
  import rris_pkg::*;

  pos_t start_mem [RegionDepth];
  pos_t stop_mem  [RegionDepth];

  // write on load, read every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_mem[wr_addr] <= wr_start;
      stop_mem[wr_addr]  <= wr_stop;
    end
    rd_start <= start_mem[rd_addr];
    rd_stop  <= stop_mem[rd_addr];
  end
endmodule

// ----- rtl/record_region_interval_splitter_core.sv -----
// Sequence: a record passes a directory lookup, then a region read unless its chromosome
// is skipped, a walk over the regions it steps past, and per segment a cut and a result
// that is handed out while out_ready is high.
// Throughput: one item at a time; the region walk and segment cut share one
// compare unit over a registered region table read port.
// Reset: synchronous active-high rst clears the directory valid bits and control.
// ----------------------------------------------------------------------------
// record_region_interval_splitter_core
// Cuts records into segments inside and outside sorted target regions.
// ----------------------------------------------------------------------------
`include "record_region_interval_splitter_core_defines.svh"
module record_region_interval_splitter_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      req_type,
  input  logic [5:0]                      chrom_id,
  input  logic [9:0]                      table_slot,
  input  logic [31:0]                     region_start,
  input  logic [31:0]                     region_stop,
  input  logic [9:0]                      dir_first,
  input  logic [10:0]                     dir_count,
  input  logic [31:0]                     record_begin,
  input  logic [31:0]                     record_end,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     seg_begin,
  output logic [31:0]                     seg_end,
  output logic                            in_region,
  output logic                            passed_through,
  output logic                            overflowed,
  output logic                            last_segment
);
  import rris_pkg::*;

  state_t state, state_next;

  // directory
  logic [SlotWidth-1:0]  dir_first_mem [ChromCount];
  logic [PtrWidth-1:0]   dir_count_mem [ChromCount];
  logic [ChromCount-1:0] dir_valid;
  logic [SlotWidth-1:0]  dir_first_q;
  logic [PtrWidth-1:0]   dir_count_q;
  logic                  dir_hit_q;

  logic [ChromWidth-1:0] current_chrom, rec_chrom;
  logic                  chrom_valid, skip_chrom;
  ptr_t                  region_ptr, region_limit;
  pos_t                  cursor_pos, span_end, rec_begin;
  logic [SegCntWidth-1:0] seg_cnt;
  logic                  seg_stepped;
  logic                  out_last;
  result_t               res, res_next;
  logic                  res_load;

  logic  accept;
  pos_t  rd_start, rd_stop;
  pos_t  clamp_end;
  logic  chrom_change, dir_empty, dir_skip;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == ST_IDLE);
  assign clamp_end = (record_end < record_begin) ? record_begin : record_end;

  rris_region_mem u_mem (
    .clk      (clk),
    .wr_en    (accept && req_type == ReqRegion),
    .wr_addr  (table_slot),
    .wr_start (region_start),
    .wr_stop  (region_stop),
    .rd_addr  (region_ptr[SlotWidth-1:0]),
    .rd_start (rd_start),
    .rd_stop  (rd_stop)
  );

  // shared compare unit
  logic at_limit, past_stop, before_start, ptr_inc, step_region;
  pos_t seg_e;
  logic seg_inr;
  assign at_limit     = (region_ptr == region_limit);
  assign past_stop    = (cursor_pos > rd_stop);
  assign before_start = (cursor_pos <= rd_start);
  assign step_region  = past_stop && !seg_stepped;
  always_comb begin
    pos_t lim;
    lim     = before_start ? rd_start : rd_stop;
    seg_e   = (lim < span_end) ? lim : span_end;
    seg_inr = !past_stop && (seg_e > rd_start);
  end

  // directory lookup for the record just taken
  assign chrom_change = !chrom_valid || (rec_chrom != current_chrom);
  assign dir_empty    = !dir_hit_q || (dir_count_q == '0);
  assign dir_skip     = chrom_change ? dir_empty : skip_chrom;

  // directory write, registered read on record transfer
  always_ff @(posedge clk) begin
    if (accept && req_type == ReqDir) begin
      dir_first_mem[chrom_id[ChromWidth-1:0]] <= dir_first;
      dir_count_mem[chrom_id[ChromWidth-1:0]] <= dir_count;
    end
    if (accept && req_type == ReqRecord) begin
      dir_first_q <= dir_first_mem[chrom_id[ChromWidth-1:0]];
      dir_count_q <= dir_count_mem[chrom_id[ChromWidth-1:0]];
    end
  end

  // mark written directory entries
  always_ff @(posedge clk) begin
    if (rst) begin
      dir_valid <= '0;
      dir_hit_q <= 1'b0;
    end else begin
      if (accept && req_type == ReqDir) dir_valid[chrom_id[ChromWidth-1:0]] <= 1'b1;
      if (accept && req_type == ReqRecord) dir_hit_q <= dir_valid[chrom_id[ChromWidth-1:0]];
    end
  end

  // next state and result
  always_comb begin
    state_next = state;
    res_next   = res;
    res_load   = 1'b0;
    ptr_inc    = 1'b0;
    case (state)
      ST_IDLE: if (accept && req_type == ReqRecord) state_next = ST_DIR;
      ST_DIR: state_next = dir_skip ? ST_OUT : ST_WALK_RD;
      ST_WALK_RD: state_next = ST_WALK;
      ST_WALK: begin
        if (at_limit) begin
          state_next = ST_OUT;
        end else if (cursor_pos > rd_stop) begin
          ptr_inc    = 1'b1;
          state_next = ST_WALK_RD;
        end else if (span_end > rd_start) begin
          state_next = ST_SEG;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_SEG_RD: state_next = ST_SEG;
      ST_SEG: begin
        if (step_region) begin
          ptr_inc    = 1'b1;
          state_next = ST_SEG_RD;
          if (region_ptr + 1'b1 == region_limit) begin
            res_next   = '{cursor_pos, span_end, 1'b0, 1'b0, 1'b0, 1'b1};
            res_load   = 1'b1;
            ptr_inc    = 1'b0;
            state_next = ST_OUT;
          end
        end else begin
          res_load   = 1'b1;
          state_next = ST_OUT;
          if (seg_e >= span_end)
            res_next = '{cursor_pos, seg_e, seg_inr, 1'b0, 1'b0, 1'b1};
          else if (seg_cnt == SegCntWidth'(MaxSegments - 1))
            res_next = '{cursor_pos, span_end, 1'b1, 1'b0, 1'b1, 1'b1};
          else
            res_next = '{cursor_pos, seg_e, seg_inr, 1'b0, 1'b0, 1'b0};
        end
      end
      ST_OUT: if (out_ready) state_next = out_last ? ST_IDLE : ST_SEG;
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      current_chrom <= '0;
      chrom_valid   <= 1'b0;
      skip_chrom    <= 1'b0;
      region_ptr    <= '0;
      region_limit  <= '0;
      cursor_pos    <= '0;
      span_end      <= '0;
      seg_stepped   <= 1'b0;
    end else begin
      if (accept && req_type == ReqRecord) begin
        rec_begin   <= record_begin;
        rec_chrom   <= chrom_id[ChromWidth-1:0];
        span_end    <= clamp_end;
        seg_cnt     <= '0;
        seg_stepped <= 1'b0;
        res <= '{record_begin, clamp_end, 1'b0, 1'b1, 1'b0, 1'b1};
      end
      // reload the region pointer on a change of chromosome
      if (state == ST_DIR) begin
        if (chrom_change) begin
          chrom_valid   <= 1'b1;
          current_chrom <= rec_chrom;
          skip_chrom    <= dir_empty;
          if (!dir_empty) begin
            region_ptr   <= PtrWidth'(dir_first_q);
            region_limit <= PtrWidth'(dir_first_q) + dir_count_q;
          end
        end
        if (!dir_skip) cursor_pos <= rec_begin;
      end
      if (state == ST_WALK && at_limit) skip_chrom <= 1'b1;
      if (ptr_inc) region_ptr <= region_ptr + 1'b1;
      if (state == ST_SEG && ptr_inc) seg_stepped <= 1'b1;
      if (state == ST_SEG && step_region && region_ptr + 1'b1 == region_limit)
        region_ptr <= region_limit;
      if (res_load) begin
        res         <= res_next;
        seg_stepped <= 1'b0;
        if (!step_region) cursor_pos <= seg_e + 1'b1;
      end
      if (state == ST_OUT && out_ready) seg_cnt <= seg_cnt + 1'b1;
    end
  end

  assign out_last       = res.last_segment;
  assign out_valid      = (state == ST_OUT);
  assign seg_begin      = res.seg_begin;
  assign seg_end        = res.seg_end;
  assign in_region      = res.in_region;
  assign passed_through = res.passed_through;
  assign overflowed     = res.overflowed;
  assign last_segment   = res.last_segment;

  `RRIS_ASSERT_IMP(a_no_accept_busy, state != ST_IDLE, !in_ready)
  `RRIS_ASSERT_IMP(a_pass_is_last, out_valid && passed_through, last_segment)
  `RRIS_ASSERT_IMP(a_ovf_is_last, out_valid && overflowed, last_segment && in_region)
  `RRIS_ASSERT_NEXT(a_last_to_idle, out_valid && out_ready && last_segment, in_ready)
endmodule

// ----- test/record_region_interval_splitter_checker.sv -----
// ----------------------------------------------------------------------------
// record_region_interval_splitter_checker
// Watches both channels of the splitter, predicts segments for every accepted
// record and compares each output transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module record_region_interval_splitter_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [5:0]  chrom_id,
  input  logic [9:0]  table_slot,
  input  logic [31:0] region_start,
  input  logic [31:0] region_stop,
  input  logic [9:0]  dir_first,
  input  logic [10:0] dir_count,
  input  logic [31:0] record_begin,
  input  logic [31:0] record_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] seg_begin,
  input  logic [31:0] seg_end,
  input  logic        in_region,
  input  logic        passed_through,
  input  logic        overflowed,
  input  logic        last_segment,
  output int          errors,
  output int          pending,
  output int          records_seen,
  output int          segments_seen
);
  import rris_pkg::*;

  // predictor copy of the block state
  pos_t        tab_start [RegionDepth];
  pos_t        tab_stop  [RegionDepth];
  logic [9:0]  chrom_first [ChromCount];
  logic [10:0] chrom_regions [ChromCount];
  logic [5:0]  cur_chrom;
  logic        chrom_seen;
  logic        skipping;
  int unsigned walk_ptr;
  int unsigned walk_end;
  pos_t        cursor;
  pos_t        span_last;

  result_t segments_due[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic result_t seg(input pos_t b, input pos_t e, input logic inr,
                                  input logic pass, input logic ovf, input logic last);
    result_t r;
    r.seg_begin = b;
    r.seg_end = e;
    r.in_region = inr;
    r.passed_through = pass;
    r.overflowed = ovf;
    r.last_segment = last;
    return r;
  endfunction

  // cut one record into its expected segments
  task automatic split_record(input logic [5:0] chrom, input pos_t rb, input pos_t re_in);
    pos_t re, b, e, rs, rp;
    logic hit, inr;
    int n;
    re = (re_in < rb) ? rb : re_in;
    hit = 1'b0;
    n = 0;
    if (!chrom_seen || chrom != cur_chrom) begin
      chrom_seen = 1'b1;
      cur_chrom = chrom;
      skipping = (chrom_regions[chrom] == 0);
      if (!skipping) begin
        walk_ptr = chrom_first[chrom];
        walk_end = chrom_first[chrom] + chrom_regions[chrom];
      end
    end
    if (!skipping) begin
      cursor = rb;
      span_last = re;
      while (walk_ptr != walk_end && rb > tab_stop[walk_ptr % RegionDepth]) walk_ptr++;
      if (walk_ptr == walk_end) skipping = 1'b1;
      else hit = (re > tab_start[walk_ptr % RegionDepth]);
    end
    if (!hit) begin
      segments_due.push_back(seg(rb, re, 1'b0, 1'b1, 1'b0, 1'b1));
      return;
    end
    forever begin
      b = cursor;
      if (cursor > tab_stop[walk_ptr % RegionDepth]) walk_ptr++;
      if (walk_ptr == walk_end) begin
        segments_due.push_back(seg(b, span_last, 1'b0, 1'b0, 1'b0, 1'b1));
        return;
      end
      rs = tab_start[walk_ptr % RegionDepth];
      rp = tab_stop[walk_ptr % RegionDepth];
      if (cursor <= rs) e = (rs < span_last) ? rs : span_last;
      else e = (rp < span_last) ? rp : span_last;
      inr = (cursor <= rp) && (e > rs);
      cursor = e + 1;
      if (e >= span_last) begin
        segments_due.push_back(seg(b, e, inr, 1'b0, 1'b0, 1'b1));
        return;
      end
      if (n == MaxSegments - 1) begin
        segments_due.push_back(seg(b, span_last, 1'b1, 1'b0, 1'b1, 1'b1));
        return;
      end
      segments_due.push_back(seg(b, e, inr, 1'b0, 1'b0, 1'b0));
      n++;
    end
  endtask

  // predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      foreach (chrom_regions[i]) chrom_regions[i] = '0;
      cur_chrom = '0;
      chrom_seen = 1'b0;
      skipping = 1'b0;
      walk_ptr = 0;
      walk_end = 0;
      cursor = '0;
      span_last = '0;
      errors = 0;
      records_seen = 0;
      segments_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        segments_seen++;
        if (segments_due.size() == 0) begin
          $display("[%0t] unexpected segment %0h..%0h", $realtime, seg_begin, seg_end);
          errors++;
        end else begin
          want = segments_due.pop_front();
          if (seg_begin !== want.seg_begin) report("seg_begin", seg_begin, want.seg_begin);
          if (seg_end !== want.seg_end) report("seg_end", seg_end, want.seg_end);
          if (in_region !== want.in_region) report("in_region", in_region, want.in_region);
          if (passed_through !== want.passed_through)
            report("passed_through", passed_through, want.passed_through);
          if (overflowed !== want.overflowed) report("overflowed", overflowed, want.overflowed);
          if (last_segment !== want.last_segment)
            report("last_segment", last_segment, want.last_segment);
        end
      end
      if (in_valid && in_ready) begin
        case (req_type)
          ReqRegion: begin
            tab_start[table_slot] = region_start;
            tab_stop[table_slot] = region_stop;
          end
          ReqDir: begin
            chrom_first[chrom_id] = dir_first;
            chrom_regions[chrom_id] = dir_count;
          end
          ReqRecord: begin
            records_seen++;
            split_record(chrom_id, record_begin, record_end);
          end
          default: ;
        endcase
      end
    end
    pending = segments_due.size();
  end
endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Fills a wrapping window of the region table, then runs directed and random
// directory loads, region reloads and records through the splitter under
// bursty input and stalling output; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import rris_pkg::*;

  localparam logic [1:0] ReqNone = 2'd3;
  localparam int unsigned Pitch = 4_000_000;
  // filled window: slots 960..1023 then 0..63
  localparam int unsigned FillBase  = 960;
  localparam int unsigned FillSlots = 128;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  req_type;
  logic [5:0]  chrom_id;
  logic [9:0]  table_slot;
  logic [31:0] region_start;
  logic [31:0] region_stop;
  logic [9:0]  dir_first;
  logic [10:0] dir_count;
  logic [31:0] record_begin;
  logic [31:0] record_end;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] seg_begin;
  logic [31:0] seg_end;
  logic        in_region;
  logic        passed_through;
  logic        overflowed;
  logic        last_segment;
  int          errors;
  int          pending;
  int          records_seen;
  int          segments_seen;

  // tb-side copy of the directory, used to aim records at regions
  int unsigned first_of [ChromCount];
  int unsigned count_of [ChromCount];
  int          burst_left;

  record_region_interval_splitter_core dut (.*);
  record_region_interval_splitter_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous run limit
  initial begin
    #8ms;
    $display("timeout with %0d segments outstanding", pending);
    $display("FAILURE");
    $finish;
  end

  // receiver stall pattern: switches at random between four modes
  initial begin
    int mode;
    int cnt;
    out_ready = 1'b0;
    cnt = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (cnt == 0) begin
        mode = $urandom_range(0, 3);
        cnt = $urandom_range(50, 400);
      end
      cnt--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ((cnt % 8) < 2);
        default: out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  function automatic int unsigned slot_of(input int unsigned j);
    return (FillBase + j) % RegionDepth;
  endfunction

  // drive one item and hold it until transfer, with bursts and gaps between
  task automatic send(input logic [1:0] kind, input logic [5:0] chrom, input logic [9:0] slot,
                      input logic [31:0] rs, input logic [31:0] rp, input logic [9:0] first,
                      input logic [10:0] cnt, input logic [31:0] rb, input logic [31:0] re);
    int gap;
    in_valid <= 1'b1;
    req_type <= kind;
    chrom_id <= chrom;
    table_slot <= slot;
    region_start <= rs;
    region_stop <= rp;
    dir_first <= first;
    dir_count <= cnt;
    record_begin <= rb;
    record_end <= re;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic load_region(input int unsigned slot, input logic [31:0] rs, input logic [31:0] rp);
    send(ReqRegion, 6'($urandom), 10'(slot), rs, rp, 10'($urandom), 11'($urandom),
         $urandom, $urandom);
  endtask

  task automatic load_dir(input int unsigned chrom, input int unsigned first, input int unsigned cnt);
    first_of[chrom] = first;
    count_of[chrom] = cnt;
    send(ReqDir, 6'(chrom), 10'($urandom), $urandom, $urandom, 10'(first), 11'(cnt),
         $urandom, $urandom);
  endtask

  task automatic record(input int unsigned chrom, input logic [31:0] rb, input logic [31:0] re);
    send(ReqRecord, 6'(chrom), 10'($urandom), $urandom, $urandom, 10'($urandom),
         11'($urandom), rb, re);
  endtask

  initial begin
    int unsigned chrom, slot, span, k, pick, wait_cycles, j0, room;
    logic [31:0] rb, rs;
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = ReqNone;
    chrom_id = '0;
    table_slot = '0;
    region_start = '0;
    region_stop = '0;
    dir_first = '0;
    dir_count = '0;
    record_begin = '0;
    record_end = '0;
    burst_left = 0;
    foreach (count_of[i]) begin
      count_of[i] = 0;
      first_of[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the window with sorted regions; directories only point inside it
    for (int j = 0; j < FillSlots; j++) begin
      slot = slot_of(j);
      load_region(slot, slot * Pitch + $urandom_range(0, 1_000_000),
                  slot * Pitch + $urandom_range(1_000_001, 3_999_999));
    end

    // directed: skipped, unloaded, whole window, last slot, ordinary chromosomes
    load_dir(0, 10, 0);
    load_dir(1, FillBase, FillSlots);
    load_dir(63, 1023, 1);
    load_dir(2, 10, 50);
    load_dir(5, 40, 3);
    record(0, 32'd5, 32'd9);
    record(40, 32'd0, 32'hffff_ffff);
    record(1, 32'd0, 32'hffff_ffff);
    record(2, 10 * Pitch + 2_000_000, 10 * Pitch);
    record(2, 20 * Pitch, 40 * Pitch);
    record(2, 30 * Pitch, 31 * Pitch);
    record(63, 32'hffff_ffff, 32'd0);
    record(63, 1023 * Pitch, 32'hffff_ffff);
    send(ReqNone, 6'h3f, 10'h3ff, '1, '1, '1, '1, '1, '1);
    record(5, 40 * Pitch, 41 * Pitch + 500);
    record(5, 41 * Pitch, 42 * Pitch + 3_999_999);
    record(5, 40 * Pitch, 40 * Pitch + 10);
    record(5, 32'd0, 32'd0);

    // random: mostly records walking forward through loaded chromosomes
    for (int n = 0; n < 174; n++) begin
      pick = $urandom_range(0, 99);
      chrom = $urandom_range(0, 7);
      if (pick < 12) begin
        cnt_pick: begin
          j0 = $urandom_range(0, FillSlots - 1);
          room = FillSlots - j0;
          k = ($urandom_range(0, 9) == 0) ? room
                                          : $urandom_range(0, (room < 90) ? room : 90);
          load_dir(chrom, slot_of(j0), k);
        end
      end else if (pick < 22) begin
        slot = slot_of($urandom_range(0, FillSlots - 1));
        rs = slot * Pitch + $urandom_range(0, 1_900_000);
        load_region(slot, rs, rs + $urandom_range(0, 2_000_000));
      end else if (pick < 25) begin
        send(ReqNone, 6'($urandom), 10'($urandom), $urandom, $urandom, 10'($urandom),
             11'($urandom), $urandom, $urandom);
      end else if (pick < 30) begin
        record($urandom_range(0, 63), $urandom, $urandom);
      end else begin
        slot = (first_of[chrom] + $urandom_range(0, count_of[chrom] + 2)) % RegionDepth;
        rb = slot * Pitch + $urandom_range(0, Pitch - 1);
        span = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 300_000_000)
                                           : $urandom_range(0, 9_000_000);
        if ($urandom_range(0, 15) == 0) record(chrom, rb, rb - $urandom_range(1, 1000));
        else record(chrom, rb, rb + span);
      end
    end

    in_valid <= 1'b0;
    req_type <= ReqNone;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 200_000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (3000) @(posedge clk);
    $display("covered %0d records into %0d segments, with table and directory reloads",
             records_seen, segments_seen);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d segments never arrived", errors, pending);
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ----- record_region_interval_splitter_core.f -----
+incdir+rtl
rtl/rris_pkg.sv
rtl/rris_region_mem.sv
rtl/record_region_interval_splitter_core.sv
test/record_region_interval_splitter_checker.sv
test/testbench.sv
